### src/rtnb_pkg.sv
// Shared types, widths and helpers for the radix tree node builder.
package rtnb_pkg;

	localparam int MAX_LEAVES = 1024;
	localparam int ADDR_W     = $clog2(MAX_LEAVES);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int CODE_W     = 32;
	localparam int LEN_W      = ADDR_W + 2;
	localparam int POS_W      = ADDR_W + 4;
	localparam int DELTA_W    = 8;
	localparam int CLZ_W      = $clog2(CODE_W) + 1;

	localparam logic signed [DELTA_W-1:0] DELTA_NONE = -8'sd1;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIR_R_A,
		S_DIR_R_E,
		S_DIR_L_E,
		S_EXP_A,
		S_EXP_E,
		S_BIN_A,
		S_BIN_E,
		S_NODE_A,
		S_NODE_E,
		S_SPL_A,
		S_SPL_E,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] node;
		logic [ADDR_W-1:0] left_child;
		logic              left_is_leaf;
		logic [ADDR_W-1:0] right_child;
		logic              right_is_leaf;
		logic              is_root;
		logic              bad_node;
	} rsp_t;

	// leading zero count, 32 for an all-zero word
	function automatic logic [CLZ_W-1:0] clz32(input logic [CODE_W-1:0] v);
		logic [CLZ_W-1:0] n;
		n = CLZ_W'(CODE_W);
		for (int b = 0; b < CODE_W; b++) begin
			if (v[b]) n = CLZ_W'(CODE_W - 1 - b);
		end
		return n;
	endfunction

endpackage

### src/rtnb_if.sv
// Request and response channel interfaces.
interface rtnb_req_if;
	import rtnb_pkg::*;

	logic              valid;
	logic              ready;
	op_t               opcode;
	logic [ADDR_W-1:0] index;
	logic [CODE_W-1:0] code;

	modport source (output valid, output opcode, output index, output code, input ready);
	modport sink   (input valid, input opcode, input index, input code, output ready);
endinterface

interface rtnb_rsp_if;
	import rtnb_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] node;
	logic [ADDR_W-1:0] left_child;
	logic              left_is_leaf;
	logic [ADDR_W-1:0] right_child;
	logic              right_is_leaf;
	logic              is_root;
	logic              bad_node;

	modport source (output valid, output node, output left_child, output left_is_leaf,
		output right_child, output right_is_leaf, output is_root, output bad_node,
		input ready);
	modport sink   (input valid, input node, input left_child, input left_is_leaf,
		input right_child, input right_is_leaf, input is_root, input bad_node,
		output ready);
endinterface

### src/rtnb_prefix_unit.sv
// Common-prefix length of two leaves, ties broken by index XOR, -1 out of range.
module rtnb_prefix_unit (
	input  logic [rtnb_pkg::CODE_W-1:0]         code_a,
	input  logic [rtnb_pkg::CODE_W-1:0]         code_b,
	input  logic [rtnb_pkg::ADDR_W-1:0]         idx_a,
	input  logic [rtnb_pkg::ADDR_W-1:0]         idx_b,
	input  logic                                in_range,
	output logic signed [rtnb_pkg::DELTA_W-1:0] delta
);
	import rtnb_pkg::*;

	logic [CODE_W-1:0] x;

	assign x = code_a ^ code_b;

	always_comb begin
		if (!in_range) begin
			delta = DELTA_NONE;
		end else if (x == '0) begin
			delta = DELTA_W'(CODE_W) + DELTA_W'(clz32(CODE_W'(idx_a ^ idx_b)));
		end else begin
			delta = DELTA_W'(clz32(x));
		end
	end

endmodule

### src/radix_tree_node_builder.sv
// Radix tree node builder: code store plus child-pair search sequencer.
// Write word: ready again on the next cycle.
// Query word: the direction probes, then an address and an evaluate state per probe (e+1 range probes,
// e+1 binary steps, the range end, m <= ceil(log2(n)) split probes), then the result load, which waits
// while an earlier result is not yet accepted; ready again in the cycle after the load.
// Bad node: straight to the result load, no search. Reset: leaf_count = 1, idle, store not cleared.
module radix_tree_node_builder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         leaf_count_we,
	input  logic [rtnb_pkg::CNT_W-1:0]   leaf_count,
	rtnb_req_if.sink                     req,
	rtnb_rsp_if.source                   rsp
);
	import rtnb_pkg::*;

	logic [CODE_W-1:0] mem [MAX_LEAVES];
	logic [CODE_W-1:0] rd_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0]          leaf_count_q;
	logic [CNT_W-1:0]          n_lim;
	logic [ADDR_W-1:0]         idx_q;
	logic [CODE_W-1:0]         code_i_q;
	logic signed [POS_W-1:0]   pos_q;
	logic                      in_range_q;
	logic                      d_neg_q;
	logic signed [DELTA_W-1:0] dr_q;
	logic signed [DELTA_W-1:0] min_d_q;
	logic signed [DELTA_W-1:0] node_d_q;
	logic [LEN_W-1:0]          lmax_q;
	logic [LEN_W-1:0]          l_q;
	logic [LEN_W-1:0]          t_q;
	logic [LEN_W-1:0]          s_q;
	logic [3:0]                k_q;
	logic                      bad_q;
	rsp_t                      rsp_q;
	logic                      rsp_valid_q;

	logic                      req_fire;
	logic                      query_bad;
	logic signed [DELTA_W-1:0] delta;
	logic [LEN_W-1:0]          mag;
	logic                      mag_neg;
	logic signed [POS_W-1:0]   i_ext;
	logic signed [POS_W-1:0]   pos;
	logic                      pos_in_range;
	logic [ADDR_W-1:0]         rd_addr;
	logic [LEN_W-1:0]          split_mask;
	logic [LEN_W-1:0]          t_split;
	logic                      rsp_load;
	logic signed [POS_W-1:0]   split;
	logic signed [POS_W-1:0]   split1;
	logic signed [POS_W-1:0]   j_pos;
	logic signed [POS_W-1:0]   lo;
	logic signed [POS_W-1:0]   hi;
	rsp_t                      rsp_d;

	assign n_lim     = (leaf_count_q > CNT_W'(MAX_LEAVES)) ? CNT_W'(MAX_LEAVES) : leaf_count_q;
	assign req_fire  = req.valid && req.ready;
	// index >= n-1, with n = 0 catching everything
	assign query_bad = (CNT_W'(req.index) + CNT_W'(1)) >= n_lim;
	assign i_ext     = POS_W'(idx_q);

	rtnb_prefix_unit u_prefix (
		.code_a   (code_i_q),
		.code_b   (rd_q),
		.idx_a    (idx_q),
		.idx_b    (pos_q[ADDR_W-1:0]),
		.in_range (in_range_q),
		.delta    (delta)
	);

	// ceil(l / 2^k) for the split search
	assign split_mask = (LEN_W'(1) << k_q) - LEN_W'(1);
	assign t_split    = (l_q >> k_q) + LEN_W'(|(l_q & split_mask));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire && req.opcode == OP_QUERY) begin
					state_d = query_bad ? S_FIN : S_DIR_R_A;
				end
			end
			S_DIR_R_A: state_d = S_DIR_R_E;
			S_DIR_R_E: state_d = S_DIR_L_E;
			S_DIR_L_E: state_d = S_EXP_A;
			S_EXP_A:   state_d = S_EXP_E;
			S_EXP_E:   state_d = (delta > min_d_q) ? S_EXP_A : S_BIN_A;
			S_BIN_A:   state_d = S_BIN_E;
			S_BIN_E:   state_d = (t_q == LEN_W'(1)) ? S_NODE_A : S_BIN_A;
			S_NODE_A:  state_d = S_NODE_E;
			S_NODE_E:  state_d = (l_q == '0) ? S_FIN : S_SPL_A;
			S_SPL_A:   state_d = S_SPL_E;
			S_SPL_E:   state_d = (t_q == LEN_W'(1)) ? S_FIN : S_SPL_A;
			S_FIN:     state_d = rsp_load ? S_IDLE : S_FIN;
			default:   state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: probe offset, store address, request ready and result load
	always_comb begin
		mag       = '0;
		mag_neg   = d_neg_q;
		req.ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			S_IDLE:    req.ready = 1'b1;
			S_DIR_R_A: begin
				mag     = LEN_W'(1);
				mag_neg = 1'b0;
			end
			S_DIR_R_E: begin
				mag     = LEN_W'(1);
				mag_neg = 1'b1;
			end
			S_EXP_A:   mag = lmax_q;
			S_BIN_A:   mag = l_q + t_q;
			S_NODE_A:  mag = l_q;
			S_SPL_A:   mag = s_q + t_split;
			S_FIN:     rsp_load = !rsp_valid_q || rsp.ready;
			default:   mag = '0;
		endcase
		pos          = mag_neg ? (i_ext - POS_W'(mag)) : (i_ext + POS_W'(mag));
		pos_in_range = !pos[POS_W-1] && (pos[POS_W-2:0] < (POS_W-1)'(n_lim));
		rd_addr      = (state_q == S_IDLE) ? req.index : pos[ADDR_W-1:0];
	end

	// result assembly
	always_comb begin
		split  = d_neg_q ? (i_ext - POS_W'(s_q) - POS_W'(1)) : (i_ext + POS_W'(s_q));
		split1 = split + POS_W'(1);
		j_pos  = d_neg_q ? (i_ext - POS_W'(l_q)) : (i_ext + POS_W'(l_q));
		lo     = (i_ext < j_pos) ? i_ext : j_pos;
		hi     = (i_ext > j_pos) ? i_ext : j_pos;
		rsp_d.node = idx_q;
		if (bad_q) begin
			rsp_d.left_child    = '0;
			rsp_d.left_is_leaf  = 1'b0;
			rsp_d.right_child   = '0;
			rsp_d.right_is_leaf = 1'b0;
			rsp_d.is_root       = 1'b0;
			rsp_d.bad_node      = 1'b1;
		end else begin
			rsp_d.left_child    = split[ADDR_W-1:0];
			rsp_d.left_is_leaf  = (lo == split);
			rsp_d.right_child   = split1[ADDR_W-1:0];
			rsp_d.right_is_leaf = (hi == split1);
			rsp_d.is_root       = (idx_q == '0);
			rsp_d.bad_node      = 1'b0;
		end
	end

	// code store, registered read
	always_ff @(posedge clk) begin
		if (req_fire && req.opcode == OP_WRITE) begin
			mem[req.index] <= req.code;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			leaf_count_q <= CNT_W'(1);
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (leaf_count_we) begin
				leaf_count_q <= leaf_count;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (state_q == S_DIR_R_A || state_q == S_DIR_R_E || state_q == S_EXP_A ||
		    state_q == S_BIN_A || state_q == S_NODE_A || state_q == S_SPL_A) begin
			pos_q      <= pos;
			in_range_q <= pos_in_range;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					idx_q <= req.index;
					bad_q <= query_bad;
				end
			end
			S_DIR_R_A: code_i_q <= rd_q;
			S_DIR_R_E: dr_q <= delta;
			S_DIR_L_E: begin
				d_neg_q <= (dr_q < delta);
				min_d_q <= (dr_q < delta) ? dr_q : delta;
				lmax_q  <= LEN_W'(2);
			end
			S_EXP_E: begin
				if (delta > min_d_q) begin
					lmax_q <= lmax_q << 1;
				end else begin
					t_q <= lmax_q >> 1;
					l_q <= '0;
				end
			end
			S_BIN_E: begin
				if (delta > min_d_q) begin
					l_q <= l_q + t_q;
				end
				t_q <= t_q >> 1;
			end
			S_NODE_E: begin
				node_d_q <= delta;
				s_q      <= '0;
				k_q      <= 4'd1;
			end
			S_SPL_A: t_q <= t_split;
			S_SPL_E: begin
				if (delta > node_d_q) begin
					s_q <= s_q + t_q;
				end
				k_q <= k_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.node          = rsp_q.node;
	assign rsp.left_child    = rsp_q.left_child;
	assign rsp.left_is_leaf  = rsp_q.left_is_leaf;
	assign rsp.right_child   = rsp_q.right_child;
	assign rsp.right_is_leaf = rsp_q.right_is_leaf;
	assign rsp.is_root       = rsp_q.is_root;
	assign rsp.bad_node      = rsp_q.bad_node;

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.opcode == OP_WRITE |=> state_q == S_IDLE)
		else $error("write word left the idle state");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.opcode == OP_QUERY |=> !req.ready)
		else $error("query word did not make the block busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_node |-> rsp.left_child == '0 && rsp.right_child == '0 &&
		!rsp.left_is_leaf && !rsp.right_is_leaf && !rsp.is_root)
		else $error("bad node result carries child data");

	a_lmax_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXP_E |-> lmax_q <= LEN_W'(MAX_LEAVES))
		else $error("range expansion ran past the store");

	a_split_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPL_E |-> t_q != '0 && l_q != '0)
		else $error("split search step is empty");

endmodule
